@@ design/bpc_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bpc_pkg
// Shared types and codes for the button press classifier.
// -----------------------------------------------------------------------------
package bpc_pkg;

	localparam int TIMER_W = 16;
	localparam int DT_W    = 8;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int EV_W    = 3;
	localparam int CNT_W   = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_BELL_HOLD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOOST_HOLD   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_HOLD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW = 3'd5;

	localparam logic [CFG_W-1:0] RST_BELL_HOLD    = 16'd500;
	localparam logic [CFG_W-1:0] RST_BOOST_HOLD   = 16'd150;
	localparam logic [CFG_W-1:0] RST_RESET_HOLD   = 16'd500;
	localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd20;
	localparam logic [CFG_W-1:0] RST_LONG_HOLD    = 16'd3000;
	localparam logic [CFG_W-1:0] RST_CLICK_WINDOW = 16'd500;

	localparam logic [EV_W-1:0] EV_NONE         = 3'd0;
	localparam logic [EV_W-1:0] EV_CLICK        = 3'd1;
	localparam logic [EV_W-1:0] EV_HELD         = 3'd2;
	localparam logic [EV_W-1:0] EV_LONG         = 3'd3;
	localparam logic [EV_W-1:0] EV_DOUBLE       = 3'd4;
	localparam logic [EV_W-1:0] EV_HOLD_RELEASE = 3'd4;
	localparam logic [EV_W-1:0] EV_CONFIRM      = 3'd5;

	typedef enum logic [2:0] {
		PH_IDLE         = 3'd0,
		PH_PRESSED      = 3'd1,
		PH_HELD         = 3'd2,
		PH_LONG         = 3'd3,
		PH_CLICK        = 3'd4,
		PH_RELEASE_WAIT = 3'd5
	} bpc_phase_t;

	typedef struct packed {
		logic [EV_W-1:0] ev;
		logic            click;
		logic            short_rel;
		logic            hold_rel;
	} bpc_lane_st_t;

	typedef struct packed {
		logic [1:0]      bell;
		logic [EV_W-1:0] boost;
		logic [EV_W-1:0] reset;
	} bpc_evt_t;

endpackage

@@ design/bpc_poll_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bpc_poll_if
// Poll pass channel: elapsed time and the three button levels.
// -----------------------------------------------------------------------------
interface bpc_poll_if;
	logic       valid;
	logic       ready;
	logic [7:0] elapsed_ms;
	logic       bell_pressed;
	logic       boost_pressed;
	logic       reset_pressed;

	modport source (output valid, elapsed_ms, bell_pressed, boost_pressed, reset_pressed,
		input ready);
	modport sink (input valid, elapsed_ms, bell_pressed, boost_pressed, reset_pressed,
		output ready);
endinterface

@@ design/bpc_evt_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bpc_evt_if
// Event channel: one word of button events per poll pass.
// -----------------------------------------------------------------------------
interface bpc_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] bell_event;
	logic [2:0] boost_event;
	logic [2:0] reset_event;

	modport source (output valid, bell_event, boost_event, reset_event, input ready);
	modport sink (input valid, bell_event, boost_event, reset_event, output ready);
endinterface

@@ design/button_press_classifier.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// button_press_classifier
// Three parallel button lanes and a merge stage classifying each poll pass.
// -----------------------------------------------------------------------------
//  channel | direction | word
//  poll    | sink      | elapsed_ms, bell/boost/reset_pressed
//  evt     | source    | bell_event, boost_event, reset_event
//  cfg     | sink      | cfg_we, cfg_index, cfg_data (write only)
//
//  One poll word is taken every cycle while poll.ready is high.
//  All lanes and the merge stage update state in the cycle of acceptance.
//  A two-entry output buffer holds event words while evt is stalled;
//  poll.ready drops only when both entries are full.
//  Reset clears all phases, timers, windows, the click count and the buffer.
module button_press_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	bpc_poll_if.sink                      poll,
	bpc_evt_if.source                     evt,
	input  logic                          cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpc_pkg::CFG_W-1:0]     cfg_data
);

	logic [bpc_pkg::CFG_W-1:0] bell_hold_q, boost_hold_q, reset_hold_q;
	logic [bpc_pkg::CFG_W-1:0] debounce_q, long_hold_q, click_window_q;

	bpc_pkg::bpc_lane_st_t st_bell, st_boost, st_reset;
	bpc_pkg::bpc_evt_t     res, out_q, skid_q;
	logic                  out_vld_q, skid_vld_q;
	logic                  acc, pop;

	assign poll.ready = !skid_vld_q;
	assign acc        = poll.valid && poll.ready;
	assign pop        = evt.valid && evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bell_hold_q    <= bpc_pkg::RST_BELL_HOLD;
			boost_hold_q   <= bpc_pkg::RST_BOOST_HOLD;
			reset_hold_q   <= bpc_pkg::RST_RESET_HOLD;
			debounce_q     <= bpc_pkg::RST_DEBOUNCE;
			long_hold_q    <= bpc_pkg::RST_LONG_HOLD;
			click_window_q <= bpc_pkg::RST_CLICK_WINDOW;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpc_pkg::CFG_BELL_HOLD:    bell_hold_q    <= cfg_data;
				bpc_pkg::CFG_BOOST_HOLD:   boost_hold_q   <= cfg_data;
				bpc_pkg::CFG_RESET_HOLD:   reset_hold_q   <= cfg_data;
				bpc_pkg::CFG_DEBOUNCE:     debounce_q     <= cfg_data;
				bpc_pkg::CFG_LONG_HOLD:    long_hold_q    <= cfg_data;
				bpc_pkg::CFG_CLICK_WINDOW: click_window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bpc_lane u_lane_bell (
		.clk(clk), .arst_n(arst_n), .en(acc), .dt(poll.elapsed_ms),
		.pressed(poll.bell_pressed), .hold_ms(bell_hold_q),
		.debounce_ms(debounce_q), .long_hold_ms(long_hold_q), .st(st_bell)
	);

	bpc_lane u_lane_boost (
		.clk(clk), .arst_n(arst_n), .en(acc), .dt(poll.elapsed_ms),
		.pressed(poll.boost_pressed), .hold_ms(boost_hold_q),
		.debounce_ms(debounce_q), .long_hold_ms(long_hold_q), .st(st_boost)
	);

	bpc_lane u_lane_reset (
		.clk(clk), .arst_n(arst_n), .en(acc), .dt(poll.elapsed_ms),
		.pressed(poll.reset_pressed), .hold_ms(reset_hold_q),
		.debounce_ms(debounce_q), .long_hold_ms(long_hold_q), .st(st_reset)
	);

	bpc_merge u_merge (
		.clk(clk), .arst_n(arst_n), .en(acc), .dt(poll.elapsed_ms),
		.click_window_ms(click_window_q), .st_bell(st_bell),
		.st_boost(st_boost), .st_reset(st_reset), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q)
				skid_vld_q <= 1'b0;
			else
				out_vld_q <= acc;
		end else if (acc) begin
			if (!out_vld_q)
				out_vld_q <= 1'b1;
			else
				skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q)
				out_q <= skid_q;
			else if (acc)
				out_q <= res;
		end else if (acc) begin
			if (!out_vld_q)
				out_q <= res;
			else
				skid_q <= res;
		end
	end

	assign evt.valid       = out_vld_q;
	assign evt.bell_event  = out_q.bell;
	assign evt.boost_event = out_q.boost;
	assign evt.reset_event = out_q.reset;

endmodule

@@ design/bpc_lane.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bpc_lane
// Per-button machine: debounce, press, hold, long hold, click, release wait.
// -----------------------------------------------------------------------------
module bpc_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [bpc_pkg::DT_W-1:0]      dt,
	input  logic                          pressed,
	input  logic [bpc_pkg::CFG_W-1:0]     hold_ms,
	input  logic [bpc_pkg::CFG_W-1:0]     debounce_ms,
	input  logic [bpc_pkg::CFG_W-1:0]     long_hold_ms,
	output bpc_pkg::bpc_lane_st_t         st
);

	bpc_pkg::bpc_phase_t               phase_q, phase_d;
	logic [bpc_pkg::TIMER_W-1:0]       hold_rem_q, hold_rem_d, hold_rem_t;
	logic [bpc_pkg::TIMER_W-1:0]       deb_rem_q, deb_rem_d, deb_rem_t;
	logic                              hold_act_q, hold_act_d;
	logic                              deb_act_q, deb_act_d;
	logic [bpc_pkg::TIMER_W-1:0]       dt_w;
	logic                              hold_exp;

	assign dt_w = {{(bpc_pkg::TIMER_W - bpc_pkg::DT_W){1'b0}}, dt};

	// run timers down, saturating at zero
	assign hold_rem_t = !hold_act_q ? hold_rem_q :
		(hold_rem_q > dt_w) ? hold_rem_q - dt_w : '0;
	assign deb_rem_t = !deb_act_q ? deb_rem_q :
		(deb_rem_q > dt_w) ? deb_rem_q - dt_w : '0;
	assign hold_exp = hold_act_q && (hold_rem_t == '0);

	always_comb begin
		phase_d    = phase_q;
		hold_rem_d = hold_rem_t;
		hold_act_d = hold_act_q;
		deb_rem_d  = deb_rem_t;
		deb_act_d  = deb_act_q;
		unique case (phase_q)
			bpc_pkg::PH_IDLE: begin
				if (pressed) begin
					hold_act_d = 1'b1;
					hold_rem_d = hold_ms;
					if (!deb_act_q) begin
						deb_act_d = 1'b1;
						deb_rem_d = debounce_ms;
					end
				end else begin
					hold_act_d = 1'b0;
					hold_rem_d = '0;
					deb_act_d  = 1'b0;
					deb_rem_d  = '0;
				end
				if (deb_act_d && (deb_rem_d == '0))
					phase_d = bpc_pkg::PH_PRESSED;
			end
			bpc_pkg::PH_PRESSED: begin
				if (hold_exp) begin
					hold_act_d = 1'b1;
					hold_rem_d = long_hold_ms;
					phase_d    = bpc_pkg::PH_HELD;
				end else if (!pressed) begin
					phase_d = bpc_pkg::PH_CLICK;
				end
			end
			bpc_pkg::PH_HELD: begin
				if (!pressed)
					phase_d = bpc_pkg::PH_RELEASE_WAIT;
				else if (hold_exp)
					phase_d = bpc_pkg::PH_LONG;
			end
			bpc_pkg::PH_LONG: phase_d = bpc_pkg::PH_RELEASE_WAIT;
			bpc_pkg::PH_CLICK: phase_d = bpc_pkg::PH_RELEASE_WAIT;
			bpc_pkg::PH_RELEASE_WAIT: begin
				hold_act_d = 1'b0;
				hold_rem_d = '0;
				deb_act_d  = 1'b0;
				deb_rem_d  = '0;
				if (!pressed)
					phase_d = bpc_pkg::PH_IDLE;
			end
			default: phase_d = bpc_pkg::PH_IDLE;
		endcase
	end

	always_comb begin
		st = '0;
		unique case (phase_q)
			bpc_pkg::PH_PRESSED: st.short_rel = !hold_exp && !pressed;
			bpc_pkg::PH_HELD: begin
				st.ev       = bpc_pkg::EV_HELD;
				st.hold_rel = !pressed;
			end
			bpc_pkg::PH_LONG: st.ev = bpc_pkg::EV_LONG;
			bpc_pkg::PH_CLICK: begin
				st.ev    = bpc_pkg::EV_CLICK;
				st.click = 1'b1;
			end
			default: st = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= bpc_pkg::PH_IDLE;
			hold_rem_q <= '0;
			hold_act_q <= 1'b0;
			deb_rem_q  <= '0;
			deb_act_q  <= 1'b0;
		end else if (en) begin
			phase_q    <= phase_d;
			hold_rem_q <= hold_rem_d;
			hold_act_q <= hold_act_d;
			deb_rem_q  <= deb_rem_d;
			deb_act_q  <= deb_act_d;
		end
	end

endmodule

@@ design/bpc_merge.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bpc_merge
// Combines lane status into one event word; owns click windows and count.
// -----------------------------------------------------------------------------
module bpc_merge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [bpc_pkg::DT_W-1:0]  dt,
	input  logic [bpc_pkg::CFG_W-1:0] click_window_ms,
	input  bpc_pkg::bpc_lane_st_t     st_bell,
	input  bpc_pkg::bpc_lane_st_t     st_boost,
	input  bpc_pkg::bpc_lane_st_t     st_reset,
	output bpc_pkg::bpc_evt_t         res
);

	logic [bpc_pkg::TIMER_W-1:0] w0_rem_q, w0_rem_t, w0_rem_d;
	logic [bpc_pkg::TIMER_W-1:0] w1_rem_q, w1_rem_t, w1_rem_d;
	logic                        w0_act_q, w0_act_d;
	logic                        w1_act_q, w1_act_d;
	logic [bpc_pkg::CNT_W-1:0]   cnt_q, cnt_d;
	logic [bpc_pkg::TIMER_W-1:0] dt_w;

	assign dt_w = {{(bpc_pkg::TIMER_W - bpc_pkg::DT_W){1'b0}}, dt};

	assign w0_rem_t = !w0_act_q ? w0_rem_q :
		(w0_rem_q > dt_w) ? w0_rem_q - dt_w : '0;
	assign w1_rem_t = !w1_act_q ? w1_rem_q :
		(w1_rem_q > dt_w) ? w1_rem_q - dt_w : '0;

	always_comb begin
		res.bell  = st_bell.ev[1:0];
		res.boost = st_boost.ev;
		w0_act_d  = w0_act_q;
		w0_rem_d  = w0_rem_t;
		if (st_boost.click) begin
			if (!w0_act_q) begin
				w0_act_d = 1'b1;
				w0_rem_d = click_window_ms;
			end else begin
				w0_act_d  = 1'b0;
				w0_rem_d  = '0;
				res.boost = bpc_pkg::EV_DOUBLE;
			end
		end
		if (w0_act_d && (w0_rem_d == '0)) begin
			w0_act_d = 1'b0;
			w0_rem_d = '0;
		end

		cnt_d     = cnt_q + {{(bpc_pkg::CNT_W - 1){1'b0}}, st_reset.short_rel};
		res.reset = st_reset.hold_rel ? bpc_pkg::EV_HOLD_RELEASE : st_reset.ev;
		w1_act_d  = w1_act_q;
		w1_rem_d  = w1_rem_t;
		if (st_reset.click && !w1_act_q && (cnt_d == bpc_pkg::CNT_W'(1))) begin
			w1_act_d = 1'b1;
			w1_rem_d = click_window_ms;
		end
		// window end: confirm a lone click, drop the count
		if (w1_act_d && (w1_rem_d == '0)) begin
			if (cnt_d == bpc_pkg::CNT_W'(1))
				res.reset = bpc_pkg::EV_CONFIRM;
			cnt_d    = '0;
			w1_act_d = 1'b0;
			w1_rem_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_rem_q <= '0;
			w0_act_q <= 1'b0;
			w1_rem_q <= '0;
			w1_act_q <= 1'b0;
			cnt_q    <= '0;
		end else if (en) begin
			w0_rem_q <= w0_rem_d;
			w0_act_q <= w0_act_d;
			w1_rem_q <= w1_rem_d;
			w1_act_q <= w1_act_d;
			cnt_q    <= cnt_d;
		end
	end

endmodule

@@ design/bpc_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// bpc_checker
// Port-level checks on the button press classifier.
// -----------------------------------------------------------------------------
module bpc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       poll_valid,
	input logic       poll_ready,
	input logic       evt_valid,
	input logic       evt_ready,
	input logic [1:0] bell_event,
	input logic [2:0] boost_event,
	input logic [2:0] reset_event
);

	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(bell_event)
			&& $stable(boost_event) && $stable(reset_event))
		else $error("event word changed while stalled");

	a_accept_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		poll_valid && poll_ready |=> evt_valid)
		else $error("accepted poll word gave no event word");

	a_stall_needs_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!poll_ready |-> evt_valid)
		else $error("poll stalled with no event word pending");

	a_boost_code: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> (boost_event != 3'd5) && (boost_event != 3'd6)
			&& (boost_event != 3'd7))
		else $error("boost event code out of range");

	a_reset_code: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> (reset_event != 3'd6) && (reset_event != 3'd7))
		else $error("reset event code out of range");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.poll_valid(poll.valid),
	.poll_ready(poll.ready),
	.evt_valid(evt.valid),
	.evt_ready(evt.ready),
	.bell_event(evt.bell_event),
	.boost_event(evt.boost_event),
	.reset_event(evt.reset_event)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the button press classifier.
// A table of directed poll words runs first, then phases of random press
// patterns under several timing settings (minimum, zero, maximum, a reset
// click storm that wraps the click count). Every event word is compared field
// by field against the table row or a cycle-free model of the three lanes.
// -----------------------------------------------------------------------------
module tb;

	localparam int BTN_BELL  = 0;
	localparam int BTN_BOOST = 1;
	localparam int BTN_RESET = 2;
	localparam int WIN_BOOST = 0;
	localparam int WIN_RESET = 1;

	localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [bpc_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef enum logic [1:0] {
		ROW_POLL,
		ROW_POLL_CHECKED,
		ROW_CFG
	} row_kind_t;

	// lv: bell, boost, reset from msb to lsb
	typedef struct packed {
		row_kind_t                         kind;
		logic [bpc_pkg::DT_W-1:0]          dt;
		logic [2:0]                        lv;
		bpc_pkg::bpc_evt_t                 want;
		logic [bpc_pkg::CFG_IDX_W-1:0]     idx;
		logic [bpc_pkg::CFG_W-1:0]         data;
	} plan_row_t;

	localparam int PLAN_ROWS = 32;

	logic clk = 1'b0;
	logic arst_n;
	logic                          cfg_we;
	logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bpc_pkg::CFG_W-1:0]     cfg_data;

	bpc_poll_if poll ();
	bpc_evt_if  evt ();

	button_press_classifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll      (poll),
		.evt       (evt),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model state
	logic [bpc_pkg::CFG_W-1:0]     reg_val [6];
	bpc_pkg::bpc_phase_t           ph [3];
	logic [bpc_pkg::TIMER_W-1:0]   hold_left [3];
	logic                          hold_on [3];
	logic [bpc_pkg::TIMER_W-1:0]   deb_left [3];
	logic                          deb_on [3];
	logic [bpc_pkg::TIMER_W-1:0]   win_left [2];
	logic                          win_on [2];
	logic [bpc_pkg::CNT_W-1:0]     reset_clicks;

	bpc_pkg::bpc_evt_t expected_evts [$];
	int errors;
	int send_pct;
	int recv_pct;

	// press pattern generator
	logic btn_lvl [3];
	int   run_left [3];

	plan_row_t plan [PLAN_ROWS] = '{
		'{ROW_POLL_CHECKED, 8'd255, 3'b111,
			'{bpc_pkg::EV_NONE[1:0], bpc_pkg::EV_NONE, bpc_pkg::EV_NONE},
			bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd255, 3'b111, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd255, 3'b000, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd255, 3'b000, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd255, 3'b000, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL_CHECKED, 8'd255, 3'b000,
			'{bpc_pkg::EV_NONE[1:0], bpc_pkg::EV_NONE, bpc_pkg::EV_CONFIRM},
			bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_CFG, 8'd0, 3'b000, '0, bpc_pkg::CFG_BELL_HOLD,    16'd10},
		'{ROW_CFG, 8'd0, 3'b000, '0, bpc_pkg::CFG_BOOST_HOLD,   16'd10},
		'{ROW_CFG, 8'd0, 3'b000, '0, bpc_pkg::CFG_RESET_HOLD,   16'd10},
		'{ROW_CFG, 8'd0, 3'b000, '0, bpc_pkg::CFG_DEBOUNCE,     16'd5},
		'{ROW_CFG, 8'd0, 3'b000, '0, bpc_pkg::CFG_LONG_HOLD,    16'd10},
		'{ROW_CFG, 8'd0, 3'b000, '0, bpc_pkg::CFG_CLICK_WINDOW, 16'd600},
		'{ROW_POLL,         8'd5, 3'b111, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd5, 3'b111, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd5, 3'b011, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL_CHECKED, 8'd5, 3'b011,
			'{bpc_pkg::EV_CLICK[1:0], bpc_pkg::EV_NONE, bpc_pkg::EV_NONE},
			bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL_CHECKED, 8'd5, 3'b010,
			'{bpc_pkg::EV_NONE[1:0], bpc_pkg::EV_HELD, bpc_pkg::EV_HOLD_RELEASE},
			bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd5, 3'b010, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd5, 3'b010, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd0, 3'b000, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd0, 3'b011, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd5, 3'b011, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd5, 3'b000, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd0, 3'b000, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd0, 3'b000, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd0, 3'b010, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd5, 3'b010, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd5, 3'b000, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL_CHECKED, 8'd0, 3'b000,
			'{bpc_pkg::EV_NONE[1:0], bpc_pkg::EV_DOUBLE, bpc_pkg::EV_NONE},
			bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd255, 3'b000, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL,         8'd255, 3'b000, '0, bpc_pkg::CFG_BELL_HOLD, 16'd0},
		'{ROW_POLL_CHECKED, 8'd255, 3'b000,
			'{bpc_pkg::EV_NONE[1:0], bpc_pkg::EV_NONE, bpc_pkg::EV_CONFIRM},
			bpc_pkg::CFG_BELL_HOLD, 16'd0}
	};

	function automatic logic [bpc_pkg::TIMER_W-1:0] run_down(
		logic [bpc_pkg::TIMER_W-1:0] left, logic on, logic [bpc_pkg::DT_W-1:0] dt);
		if (!on)
			return left;
		return (left > bpc_pkg::TIMER_W'(dt)) ? left - bpc_pkg::TIMER_W'(dt) : '0;
	endfunction

	function automatic logic timed_out(logic on, logic [bpc_pkg::TIMER_W-1:0] left);
		return on && left == '0;
	endfunction

	task automatic lane_step(input int b, input logic pressed,
		output logic [bpc_pkg::EV_W-1:0] ev);
		ev = bpc_pkg::EV_NONE;
		case (ph[b])
			bpc_pkg::PH_IDLE: begin
				if (pressed) begin
					hold_on[b] = 1'b1;
					hold_left[b] = reg_val[int'(bpc_pkg::CFG_BELL_HOLD) + b];
					if (!deb_on[b]) begin
						deb_on[b] = 1'b1;
						deb_left[b] = reg_val[bpc_pkg::CFG_DEBOUNCE];
					end
				end else begin
					hold_on[b] = 1'b0;
					hold_left[b] = '0;
					deb_on[b] = 1'b0;
					deb_left[b] = '0;
				end
				if (timed_out(deb_on[b], deb_left[b]))
					ph[b] = bpc_pkg::PH_PRESSED;
			end
			bpc_pkg::PH_PRESSED: begin
				if (!timed_out(hold_on[b], hold_left[b])) begin
					if (!pressed) begin
						if (b == BTN_RESET)
							reset_clicks = reset_clicks + 1'b1;
						ph[b] = bpc_pkg::PH_CLICK;
					end
				end else begin
					hold_on[b] = 1'b1;
					hold_left[b] = reg_val[bpc_pkg::CFG_LONG_HOLD];
					ph[b] = bpc_pkg::PH_HELD;
				end
			end
			bpc_pkg::PH_HELD: begin
				ev = bpc_pkg::EV_HELD;
				if (!pressed) begin
					if (b == BTN_RESET)
						ev = bpc_pkg::EV_HOLD_RELEASE;
					ph[b] = bpc_pkg::PH_RELEASE_WAIT;
				end else if (timed_out(hold_on[b], hold_left[b])) begin
					ph[b] = bpc_pkg::PH_LONG;
				end
			end
			bpc_pkg::PH_LONG: begin
				ev = bpc_pkg::EV_LONG;
				ph[b] = bpc_pkg::PH_RELEASE_WAIT;
			end
			bpc_pkg::PH_CLICK: begin
				ev = bpc_pkg::EV_CLICK;
				ph[b] = bpc_pkg::PH_RELEASE_WAIT;
				if (b == BTN_BOOST) begin
					if (!win_on[WIN_BOOST]) begin
						win_on[WIN_BOOST] = 1'b1;
						win_left[WIN_BOOST] = reg_val[bpc_pkg::CFG_CLICK_WINDOW];
					end else begin
						win_on[WIN_BOOST] = 1'b0;
						win_left[WIN_BOOST] = '0;
						ev = bpc_pkg::EV_DOUBLE;
					end
				end else if (b == BTN_RESET) begin
					if (!win_on[WIN_RESET] && reset_clicks == bpc_pkg::CNT_W'(1)) begin
						win_on[WIN_RESET] = 1'b1;
						win_left[WIN_RESET] = reg_val[bpc_pkg::CFG_CLICK_WINDOW];
					end
				end
			end
			bpc_pkg::PH_RELEASE_WAIT: begin
				hold_on[b] = 1'b0;
				hold_left[b] = '0;
				deb_on[b] = 1'b0;
				deb_left[b] = '0;
				if (!pressed)
					ph[b] = bpc_pkg::PH_IDLE;
			end
			default: ph[b] = bpc_pkg::PH_IDLE;
		endcase
	endtask

	task automatic classify_pass(input logic [bpc_pkg::DT_W-1:0] dt, input logic [2:0] lv,
		output bpc_pkg::bpc_evt_t ev);
		logic [bpc_pkg::EV_W-1:0] e_bell;
		logic [bpc_pkg::EV_W-1:0] e_boost;
		logic [bpc_pkg::EV_W-1:0] e_reset;
		for (int b = 0; b < 3; b++) begin
			hold_left[b] = run_down(hold_left[b], hold_on[b], dt);
			deb_left[b] = run_down(deb_left[b], deb_on[b], dt);
		end
		for (int w = 0; w < 2; w++)
			win_left[w] = run_down(win_left[w], win_on[w], dt);
		lane_step(BTN_BELL, lv[2], e_bell);
		lane_step(BTN_BOOST, lv[1], e_boost);
		if (timed_out(win_on[WIN_BOOST], win_left[WIN_BOOST]))
			win_on[WIN_BOOST] = 1'b0;
		lane_step(BTN_RESET, lv[0], e_reset);
		if (timed_out(win_on[WIN_RESET], win_left[WIN_RESET])) begin
			if (reset_clicks == bpc_pkg::CNT_W'(1))
				e_reset = bpc_pkg::EV_CONFIRM;
			reset_clicks = '0;
			win_on[WIN_RESET] = 1'b0;
		end
		ev.bell = e_bell[1:0];
		ev.boost = e_boost;
		ev.reset = e_reset;
	endtask

	task automatic report(input string field, input int want, input int got);
		$display("%0t: %s expected %0d got %0d", $time, field, want, got);
		errors++;
	endtask

	// event word checker
	always @(posedge clk) begin
		bpc_pkg::bpc_evt_t want;
		if (arst_n && evt.valid === 1'b1 && evt.ready === 1'b1) begin
			if (expected_evts.size() == 0) begin
				$display("%0t: event word expected none got %0d/%0d/%0d", $time,
					evt.bell_event, evt.boost_event, evt.reset_event);
				errors++;
			end else begin
				want = expected_evts.pop_front();
				if (evt.bell_event !== want.bell)
					report("bell_event", want.bell, evt.bell_event);
				if (evt.boost_event !== want.boost)
					report("boost_event", want.boost, evt.boost_event);
				if (evt.reset_event !== want.reset)
					report("reset_event", want.reset, evt.reset_event);
			end
		end
	end

	// event sink with random stall bursts
	initial begin
		int stall;
		stall = 0;
		evt.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				evt.ready <= 1'b0;
			end else if (recv_pct != 0 && $urandom_range(0, 99) < recv_pct) begin
				stall = $urandom_range(1, 4) - 1;
				evt.ready <= 1'b0;
			end else begin
				evt.ready <= 1'b1;
			end
		end
	end

	task automatic put_word(input logic [bpc_pkg::DT_W-1:0] dt, input logic [2:0] lv,
		input logic typed, input bpc_pkg::bpc_evt_t want);
		bpc_pkg::bpc_evt_t pred;
		poll.valid <= 1'b1;
		poll.elapsed_ms <= dt;
		poll.bell_pressed <= lv[2];
		poll.boost_pressed <= lv[1];
		poll.reset_pressed <= lv[0];
		do @(posedge clk); while (poll.ready !== 1'b1);
		classify_pass(dt, lv, pred);
		expected_evts.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic hold_off();
		repeat ($urandom_range(1, 4)) begin
			poll.valid <= 1'b0;
			poll.elapsed_ms <= bpc_pkg::DT_W'($urandom);
			poll.bell_pressed <= 1'($urandom);
			poll.boost_pressed <= 1'($urandom);
			poll.reset_pressed <= 1'($urandom);
			@(negedge clk);
		end
	endtask

	task automatic send_pass(input logic [bpc_pkg::DT_W-1:0] dt, input logic [2:0] lv,
		input logic typed, input bpc_pkg::bpc_evt_t want);
		if (send_pct != 0 && $urandom_range(0, 99) < send_pct)
			hold_off();
		put_word(dt, lv, typed, want);
	endtask

	task automatic wait_drained();
		int waited;
		waited = 0;
		poll.valid <= 1'b0;
		while (expected_evts.size() != 0 && waited < 4000) begin
			@(negedge clk);
			waited++;
		end
		if (expected_evts.size() != 0) begin
			$display("%0t: %0d event words expected got none", $time, expected_evts.size());
			errors += expected_evts.size();
			expected_evts.delete();
		end
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
		input logic [bpc_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx <= bpc_pkg::CFG_CLICK_WINDOW)
			reg_val[idx] = data;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [bpc_pkg::CFG_W-1:0] bell_hold,
		input logic [bpc_pkg::CFG_W-1:0] boost_hold,
		input logic [bpc_pkg::CFG_W-1:0] reset_hold,
		input logic [bpc_pkg::CFG_W-1:0] debounce,
		input logic [bpc_pkg::CFG_W-1:0] long_hold,
		input logic [bpc_pkg::CFG_W-1:0] window);
		wait_drained();
		write_reg(bpc_pkg::CFG_BELL_HOLD, bell_hold);
		write_reg(bpc_pkg::CFG_BOOST_HOLD, boost_hold);
		write_reg(bpc_pkg::CFG_RESET_HOLD, reset_hold);
		write_reg(bpc_pkg::CFG_DEBOUNCE, debounce);
		write_reg(bpc_pkg::CFG_LONG_HOLD, long_hold);
		write_reg(bpc_pkg::CFG_CLICK_WINDOW, window);
		write_reg(CFG_SPARE_LO, bpc_pkg::CFG_W'($urandom));
		write_reg(CFG_SPARE_HI, bpc_pkg::CFG_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_run(int long_max);
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return $urandom_range(1, 3);
		if (r < 8)
			return $urandom_range(1, 15);
		return $urandom_range(1, long_max);
	endfunction

	// hold each level for a run, flip at the end, add the odd one-pass glitch
	function automatic logic [2:0] next_levels(int long_max);
		logic [2:0] lv;
		for (int b = 0; b < 3; b++) begin
			if (run_left[b] == 0) begin
				btn_lvl[b] = !btn_lvl[b];
				run_left[b] = pick_run(long_max);
			end
			run_left[b]--;
			lv[2 - b] = btn_lvl[b] ^ ($urandom_range(0, 19) == 0);
		end
		return lv;
	endfunction

	task automatic run_phase(input int n, input int dt_lo, input int dt_hi, input int long_max,
		input int s_pct, input int r_pct, input bit storm);
		logic [2:0] lv;
		send_pct = s_pct;
		recv_pct = r_pct;
		for (int i = 0; i < n; i++) begin
			lv = next_levels(long_max);
			if (storm)
				lv[0] = (i % 4 == 0);
			send_pass(bpc_pkg::DT_W'($urandom_range(dt_lo, dt_hi)), lv, 1'b0, '0);
		end
	endtask

	initial begin
		#(5_000_000);
		$display("** button_press_classifier: FAILED **");
		$finish;
	end

	initial begin
		logic in_cfg;
		errors = 0;
		send_pct = 0;
		recv_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		poll.valid = 1'b0;
		poll.elapsed_ms = '0;
		poll.bell_pressed = 1'b0;
		poll.boost_pressed = 1'b0;
		poll.reset_pressed = 1'b0;
		reg_val[bpc_pkg::CFG_BELL_HOLD] = bpc_pkg::RST_BELL_HOLD;
		reg_val[bpc_pkg::CFG_BOOST_HOLD] = bpc_pkg::RST_BOOST_HOLD;
		reg_val[bpc_pkg::CFG_RESET_HOLD] = bpc_pkg::RST_RESET_HOLD;
		reg_val[bpc_pkg::CFG_DEBOUNCE] = bpc_pkg::RST_DEBOUNCE;
		reg_val[bpc_pkg::CFG_LONG_HOLD] = bpc_pkg::RST_LONG_HOLD;
		reg_val[bpc_pkg::CFG_CLICK_WINDOW] = bpc_pkg::RST_CLICK_WINDOW;
		for (int b = 0; b < 3; b++) begin
			ph[b] = bpc_pkg::PH_IDLE;
			hold_left[b] = '0;
			hold_on[b] = 1'b0;
			deb_left[b] = '0;
			deb_on[b] = 1'b0;
			btn_lvl[b] = 1'b0;
			run_left[b] = 0;
		end
		for (int w = 0; w < 2; w++) begin
			win_left[w] = '0;
			win_on[w] = 1'b0;
		end
		reset_clicks = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_pct = 20;
		recv_pct = 20;
		in_cfg = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (!in_cfg)
					wait_drained();
				in_cfg = 1'b1;
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				if (in_cfg) begin
					cfg_we <= 1'b0;
					in_cfg = 1'b0;
				end
				send_pass(plan[i].dt, plan[i].lv, plan[i].kind == ROW_POLL_CHECKED,
					plan[i].want);
			end
		end

		set_config(bpc_pkg::RST_BELL_HOLD, bpc_pkg::RST_BOOST_HOLD, bpc_pkg::RST_RESET_HOLD,
			bpc_pkg::RST_DEBOUNCE, bpc_pkg::RST_LONG_HOLD, bpc_pkg::RST_CLICK_WINDOW);
		run_phase(120, 0, 255, 30, 20, 20, 1'b0);
		set_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		run_phase(100, 0, 3, 12, 30, 0, 1'b0);
		set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_phase(80, 0, 2, 8, 0, 30, 1'b0);
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_phase(100, 200, 255, 400, 15, 15, 1'b0);
		// reset clicks with no time passing: the count wraps inside one window
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
		run_phase(1040, 0, 0, 10, 10, 10, 1'b1);
		set_config(bpc_pkg::CFG_W'($urandom_range(1, 600)),
			bpc_pkg::CFG_W'($urandom_range(1, 600)),
			bpc_pkg::CFG_W'($urandom_range(1, 600)),
			bpc_pkg::CFG_W'($urandom_range(1, 60)),
			bpc_pkg::CFG_W'($urandom_range(1, 600)),
			bpc_pkg::CFG_W'($urandom_range(1, 600)));
		run_phase(140, 0, $urandom_range(8, 255), 30, 25, 25, 1'b0);
		set_config(bpc_pkg::CFG_W'($urandom_range(1, 300)),
			bpc_pkg::CFG_W'($urandom_range(1, 300)),
			bpc_pkg::CFG_W'($urandom_range(1, 300)),
			bpc_pkg::CFG_W'($urandom_range(1, 40)),
			bpc_pkg::CFG_W'($urandom_range(1, 300)),
			bpc_pkg::CFG_W'($urandom_range(1, 300)));
		run_phase(140, 0, 63, 25, 0, 0, 1'b0);

		wait_drained();
		if (errors == 0)
			$display("** button_press_classifier: PASSED **");
		else
			$display("** button_press_classifier: FAILED **");
		$finish;
	end

endmodule
